// ===== src/plpl_pkg.sv =====
// ---------------------------------------------------------------------------
// plpl_pkg: shared types and constants
// Item formats, command and status codes, sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package plpl_pkg;

  localparam int COORD_BITS     = 32;
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS      = 2 * DIFF_BITS;
  localparam int SEG_BITS       = 8;
  localparam int MAX_POINTS_DEF = 256;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PICK_LOW  = 2'd0,
    PICK_MID  = 2'd1,
    PICK_HIGH = 2'd2
  } pick_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_LOCATE,
    S_RD_I,
    S_RD_I1,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        [1:0]            cmd;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic        [1:0]            pick_mode;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]            status;
    logic signed [COORD_BITS-1:0] elevation;
    logic        [SEG_BITS-1:0]   segment_found;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/piecewise_linear_profile_lookup_unit.sv =====
// ---------------------------------------------------------------------------
// piecewise_linear_profile_lookup_unit: profile table with interpolating query
// Appends points to a memory, finds a query x by binary search, then
// interpolates inside the segment or picks from a vertical step.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (in_item_t)
//   out      output     out_valid_o/ out_stall_i out_item_o (out_item_t)
//
// Clear, append, no-op: S_IDLE then S_DONE. Query: an S_SEARCH_RD /
// S_SEARCH_CMP pair per search step; S_LOCATE, S_RD_I, S_RD_I1 fetch the
// segment; then an S_SCAN_RD / S_SCAN_CMP pair per point of a vertical run
// or S_MUL, the divider loop and S_FIN. The memory read port (one access per
// cycle) and the divider set the pace. Reset empties the table; no clearing
// pass. Input stalls until each item's result has entered the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_profile_lookup_unit
  import plpl_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [DIFF_BITS-1:0] HI_LIM = DIFF_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});

  state_e state_q, state_d;

  logic [CW-1:0]                cnt_q;
  logic signed [COORD_BITS-1:0] cx_q;
  logic [1:0]                   pick_q;
  logic [CW-1:0]                lo_q, hi_q;
  logic [AW-1:0]                mid_q;
  logic [AW-1:0]                idx_q;
  logic                         chk0_q;
  logic signed [COORD_BITS-1:0] x0_q, y0_q, mn_q, mx_q;
  logic [DIFF_BITS-1:0]         a_q, b_q, d_q;
  logic                         neg_q;
  out_item_t                    res_q;
  out_item_t                    out_q;
  logic                         out_valid_q;

  logic                         accept;
  logic                         out_free;
  logic [CW:0]                  mid_sum;
  logic [AW-1:0]                mid;
  logic [AW-1:0]                raddr;
  logic                         we;
  logic                         div_start;
  logic                         div_done;
  logic [PROD_BITS-1:0]         quot;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic signed [DIFF_BITS-1:0]  da, db, dd;
  logic [DIFF_BITS-1:0]         ma, mb, md;
  logic [DIFF_BITS-1:0]         span;
  logic [DIFF_BITS-1:0]         pick_mid;
  logic signed [COORD_BITS-1:0] pick_elev;
  logic [DIFF_BITS-1:0]         room;
  logic                         sat;
  logic [DIFF_BITS-1:0]         interp_sum;
  logic signed [COORD_BITS-1:0] interp_elev;
  logic [CW-1:0]                idx_next;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AW:1];
  assign idx_next = CW'(idx_q) + 1'b1;

  plpl_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wx_i    (in_item_i.coord_x),
    .wy_i    (in_item_i.coord_y),
    .raddr_i (raddr),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  plpl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (PROD_BITS'(a_q * b_q)),
    .denom_i (d_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // segment differences (rx/ry hold x[i+1], y[i+1] in S_RD_I1)
  assign da = $signed({cx_q[COORD_BITS-1], cx_q}) - $signed({x0_q[COORD_BITS-1], x0_q});
  assign db = $signed({ry[COORD_BITS-1], ry}) - $signed({y0_q[COORD_BITS-1], y0_q});
  assign dd = $signed({rx[COORD_BITS-1], rx}) - $signed({x0_q[COORD_BITS-1], x0_q});
  assign ma = da[DIFF_BITS-1] ? DIFF_BITS'(-da) : da;
  assign mb = db[DIFF_BITS-1] ? DIFF_BITS'(-db) : db;
  assign md = dd[DIFF_BITS-1] ? DIFF_BITS'(-dd) : dd;

  // vertical step pick
  assign span     = DIFF_BITS'($signed({mx_q[COORD_BITS-1], mx_q})
                    - $signed({mn_q[COORD_BITS-1], mn_q}));
  assign pick_mid = {mn_q[COORD_BITS-1], mn_q} + {1'b0, span[DIFF_BITS-1:1]};

  always_comb begin
    priority if (pick_q == PICK_HIGH) begin
      pick_elev = mx_q;
    end else if (pick_q == PICK_MID) begin
      pick_elev = pick_mid[COORD_BITS-1:0];
    end else begin
      pick_elev = mn_q;
    end
  end

  // saturating y0 +/- quotient
  always_comb begin
    if (neg_q) begin
      room       = {y0_q[COORD_BITS-1], y0_q} + (HI_LIM + 1'b1);
      interp_sum = {y0_q[COORD_BITS-1], y0_q} - quot[DIFF_BITS-1:0];
    end else begin
      room       = HI_LIM - {y0_q[COORD_BITS-1], y0_q};
      interp_sum = {y0_q[COORD_BITS-1], y0_q} + quot[DIFF_BITS-1:0];
    end
    sat = (quot[PROD_BITS-1:DIFF_BITS] != '0) || (quot[DIFF_BITS-1:0] > room);
    if (sat) begin
      interp_elev = neg_q ? ~HI_LIM[COORD_BITS-1:0] : HI_LIM[COORD_BITS-1:0];
    end else begin
      interp_elev = interp_sum[COORD_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.cmd == CMD_QUERY) ? S_SEARCH_RD : S_DONE;
        end
      end
      S_SEARCH_RD:  state_d = (lo_q < hi_q) ? S_SEARCH_CMP : S_LOCATE;
      S_SEARCH_CMP: state_d = S_SEARCH_RD;
      S_LOCATE: begin
        if (lo_q == '0) begin
          state_d = (cnt_q < CW'(2)) ? S_DONE : S_RD_I;
        end else begin
          state_d = (lo_q >= cnt_q) ? S_DONE : S_RD_I;
        end
      end
      S_RD_I: state_d = (chk0_q && rx != cx_q) ? S_DONE : S_RD_I1;
      S_RD_I1: begin
        if (rx != cx_q) begin
          state_d = (md == '0) ? S_DONE : S_MUL;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_d = (idx_next < cnt_q) ? S_SCAN_CMP : S_DONE;
      S_SCAN_CMP: state_d = (rx == cx_q) ? S_SCAN_RD : S_DONE;
      S_MUL:      state_d = S_DIV;
      S_DIV:      state_d = div_done ? S_FIN : S_DIV;
      S_FIN:      state_d = S_DONE;
      S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr     = '0;
    we        = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        we = accept && in_item_i.cmd == CMD_APPEND && cnt_q < CW'(MAX_POINTS);
      end
      S_SEARCH_RD: raddr = mid;
      S_LOCATE:    raddr = (lo_q == '0) ? '0 : AW'(lo_q - 1'b1);
      S_RD_I:      raddr = AW'(CW'(idx_q) + 1'b1);
      S_SCAN_RD:   raddr = idx_next[AW-1:0];
      S_MUL:       div_start = 1'b1;
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_item_i.cmd == CMD_CLEAR) begin
        cnt_q <= '0;
      end else if (we) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cx_q   <= in_item_i.coord_x;
          pick_q <= in_item_i.pick_mode;
          lo_q   <= '0;
          hi_q   <= cnt_q;
          res_q.status <= (in_item_i.cmd == CMD_APPEND && cnt_q >= CW'(MAX_POINTS))
                          ? ST_FULL : ST_OK;
          res_q.elevation     <= '0;
          res_q.segment_found <= '0;
        end
      end
      S_SEARCH_RD: mid_q <= mid;
      S_SEARCH_CMP: begin
        if (rx < cx_q) begin
          lo_q <= CW'(mid_q) + 1'b1;
        end else begin
          hi_q <= CW'(mid_q);
        end
      end
      S_LOCATE: begin
        chk0_q <= (lo_q == '0);
        idx_q  <= (lo_q == '0) ? '0 : AW'(lo_q - 1'b1);
        if ((lo_q == '0 && cnt_q < CW'(2)) || (lo_q != '0 && lo_q >= cnt_q)) begin
          res_q.status <= ST_RANGE;
        end
      end
      S_RD_I: begin
        x0_q <= rx;
        y0_q <= ry;
        if (chk0_q && rx != cx_q) begin
          res_q.status <= ST_RANGE;
        end
      end
      S_RD_I1: begin
        res_q.segment_found <= SEG_BITS'(idx_q);
        a_q   <= ma;
        b_q   <= mb;
        d_q   <= md;
        neg_q <= (da[DIFF_BITS-1] != db[DIFF_BITS-1]) != dd[DIFF_BITS-1];
        if (rx != cx_q) begin
          if (md == '0) begin
            res_q.elevation <= y0_q;
          end
        end else if (x0_q != cx_q) begin
          idx_q <= AW'(CW'(idx_q) + 1'b1);
          mn_q  <= ry;
          mx_q  <= ry;
        end else begin
          mn_q <= y0_q;
          mx_q <= y0_q;
        end
      end
      S_SCAN_RD: begin
        if (idx_next >= cnt_q) begin
          res_q.elevation <= pick_elev;
        end
      end
      S_SCAN_CMP: begin
        if (rx == cx_q) begin
          idx_q <= idx_next[AW-1:0];
          if (ry < mn_q) begin
            mn_q <= ry;
          end else if (ry > mx_q) begin
            mx_q <= ry;
          end
        end else begin
          res_q.elevation <= pick_elev;
        end
      end
      S_FIN: res_q.elevation <= interp_elev;
      S_DONE: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: begin
        mid_q <= mid_q;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count above table depth");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH_CMP |-> lo_q < hi_q && hi_q <= cnt_q)
    else $error("search window out of range");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.elevation == '0
      && out_q.segment_found == '0)
    else $error("failed item carries data");

endmodule

`default_nettype wire

// ===== src/plpl_store.sv =====
// ---------------------------------------------------------------------------
// plpl_store: point memory
// x and y arrays, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module plpl_store
  import plpl_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic        [AW-1:0]         waddr_i,
  input  wire logic signed [COORD_BITS-1:0] wx_i,
  input  wire logic signed [COORD_BITS-1:0] wy_i,
  input  wire logic        [AW-1:0]         raddr_i,
  output      logic signed [COORD_BITS-1:0] rx_o,
  output      logic signed [COORD_BITS-1:0] ry_o
);

  logic signed [COORD_BITS-1:0] mem_x [DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/plpl_div.sv =====
// ---------------------------------------------------------------------------
// plpl_div: restoring divider
// Unsigned PROD_BITS / DIFF_BITS, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module plpl_div
  import plpl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [PROD_BITS-1:0] numer_i,
  input  wire logic [DIFF_BITS-1:0] denom_i,
  output      logic                 done_o,
  output      logic [PROD_BITS-1:0] quot_o
);

  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  logic [CNT_BITS-1:0]  cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [PROD_BITS-1:0] nq_q;
  logic [DIFF_BITS-1:0] rem_q;
  logic [DIFF_BITS-1:0] den_q;
  logic [DIFF_BITS:0]   rem_sh;
  logic                 ge;
  logic [DIFF_BITS:0]   rem_sub;

  assign rem_sh  = {rem_q, nq_q[PROD_BITS-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(PROD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[PROD_BITS-2:0], ge};
      rem_q <= ge ? rem_sub[DIFF_BITS-1:0] : rem_sh[DIFF_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: profile lookup unit check
// Fills the point table by append items, queries it at exact points and
// inside segments, and compares every result against a local predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import plpl_pkg::*;

  localparam int NPTS = 256;
  localparam longint HI_LIM = 64'sd2147483647;
  localparam longint LO_LIM = -64'sd2147483648;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  piecewise_linear_profile_lookup_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint    tab_x [NPTS];
  longint    tab_y [NPTS];
  int        tab_n;
  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        send_idle_pct, recv_idle_pct;
  int        errors, results_seen, queries_ok, queries_range, drops;
  longint    cycles;
  bit        stim_done;

  function automatic longint lerp_segment(int i, longint xq);
    logic signed [127:0] num, d, q, r;
    d = tab_x[i+1] - tab_x[i];
    if (d == 0) return tab_y[i];
    num = (xq - tab_x[i]) * (tab_y[i+1] - tab_y[i]);  // exact in 128 bits
    q = num / d;                                       // truncates toward zero
    r = tab_y[i] + q;
    if (r > HI_LIM) r = HI_LIM;
    if (r < LO_LIM) r = LO_LIM;
    return r[63:0];
  endfunction

  function automatic out_item_t predict_lookup(in_item_t it);
    out_item_t o;
    int lo, hi, mid, i;
    bit ok;
    longint cx, mn, mx, ev;
    o = '0;
    cx = longint'(it.coord_x);
    case (cmd_e'(it.cmd))
      CMD_CLEAR: tab_n = 0;
      CMD_APPEND: begin
        if (tab_n < NPTS) begin
          tab_x[tab_n] = cx;
          tab_y[tab_n] = longint'(it.coord_y);
          tab_n++;
        end else begin
          o.status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        lo = 0; hi = tab_n; ok = 1'b1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (tab_x[mid] < cx) lo = mid + 1;
          else hi = mid;
        end
        if (lo > 0) i = lo - 1;
        else if (tab_n > 0 && tab_x[0] == cx) i = 0;
        else begin
          i = 0; ok = 1'b0;
        end
        if (!ok || i + 1 >= tab_n) begin
          o.status = ST_RANGE;
        end else begin
          o.segment_found = i[7:0];
          if (cx != tab_x[i+1]) begin
            ev = lerp_segment(i, cx);
          end else begin
            if (tab_x[i] != cx) i++;
            mn = tab_y[i]; mx = tab_y[i];
            while (i + 1 < tab_n && tab_x[i] == tab_x[i+1]) begin
              i++;
              if (tab_y[i] < mn) mn = tab_y[i];
              else if (tab_y[i] > mx) mx = tab_y[i];
            end
            if (it.pick_mode == PICK_HIGH) ev = mx;
            else if (it.pick_mode == PICK_MID) ev = (mn + mx) >>> 1;
            else ev = mn;
          end
          o.elevation = ev[31:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_item_t mk(cmd_e c, longint x, longint y, int p);
    in_item_t it;
    it.cmd = c;
    it.coord_x = x[31:0];
    it.coord_y = y[31:0];
    it.pick_mode = p[1:0];
    return it;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(0, 200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_results.push_back(predict_lookup(in_item_i));
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.status == ST_RANGE) queries_range++;
          if (e.status == ST_FULL) drops++;
          if (out_item_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_item_o.status);
            errors++;
          end
          if (out_item_o.elevation !== e.elevation) begin
            $error("elevation exp %0h got %0h", e.elevation, out_item_o.elevation);
            errors++;
          end
          if (out_item_o.segment_found !== e.segment_found) begin
            $error("segment_found exp %0d got %0d", e.segment_found,
                   out_item_o.segment_found);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // builds a sorted profile with some vertical steps, then queries it
  task automatic add_profile_phase(int npts, int nq);
    longint xs [$];
    longint x, y;
    int k, j;
    pending_items.push_back(mk(CMD_CLEAR, 0, 0, 0));
    x = longint'($signed(rnd32())) >>> $urandom_range(0, 4);
    for (k = 0; k < npts; k++) begin
      pending_items.push_back(mk(CMD_APPEND, x, longint'($signed(rnd32())), 0));
      xs.push_back(x);
      if ($urandom_range(0, 3) != 0) x = x + $urandom_range(1, 1 << $urandom_range(0, 26));
      if (x > HI_LIM) x = HI_LIM;
    end
    for (k = 0; k < nq; k++) begin
      j = $urandom_range(0, xs.size() - 1);
      case ($urandom_range(0, 4))
        0, 1: y = xs[j];
        2: y = xs[j] + $urandom_range(1, 1000);
        3: y = xs[j] - $urandom_range(0, 3);
        default: y = longint'($signed(rnd32()));
      endcase
      if (y > HI_LIM) y = HI_LIM;
      if (y < LO_LIM) y = LO_LIM;
      pending_items.push_back(mk(CMD_QUERY, y, longint'($signed(rnd32())),
                                 $urandom_range(0, 3)));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    int k;
    tab_n = 0; errors = 0; results_seen = 0; cycles = 0;
    queries_ok = 0; queries_range = 0; drops = 0; stim_done = 1'b0;
    send_idle_pct = 24; recv_idle_pct = 70;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    pending_items.push_back(mk(CMD_QUERY, 0, 0, 0));
    pending_items.push_back(mk(CMD_APPEND, 5, 7, 0));
    pending_items.push_back(mk(CMD_QUERY, 5, 0, 0));
    pending_items.push_back(mk(CMD_APPEND, LO_LIM, HI_LIM, 0));
    pending_items.push_back(mk(CMD_CLEAR, 0, 0, 0));
    pending_items.push_back(mk(CMD_APPEND, LO_LIM, LO_LIM, 0));
    pending_items.push_back(mk(CMD_APPEND, 0, HI_LIM, 0));
    pending_items.push_back(mk(CMD_APPEND, 0, LO_LIM, 0));
    pending_items.push_back(mk(CMD_APPEND, 0, 3, 0));
    pending_items.push_back(mk(CMD_APPEND, HI_LIM, LO_LIM, 0));
    pending_items.push_back(mk(CMD_APPEND, HI_LIM, HI_LIM, 0));
    for (k = 0; k < 4; k++) pending_items.push_back(mk(CMD_QUERY, 0, 0, k));
    for (k = 0; k < 4; k++) pending_items.push_back(mk(CMD_QUERY, HI_LIM, 0, k));
    pending_items.push_back(mk(CMD_QUERY, -1, 0, 0));
    pending_items.push_back(mk(CMD_QUERY, LO_LIM, 0, 1));
    pending_items.push_back(mk(CMD_QUERY, 1, 0, 2));
    pending_items.push_back(mk(CMD_NOP, -1, -1, 3));
    pending_items.push_back(mk(CMD_APPEND, -5, 9, 0));  // unsorted
    pending_items.push_back(mk(CMD_QUERY, HI_LIM - 1, -1, 0));
    wait_drained();

    // fill to capacity, then overflow
    pending_items.push_back(mk(CMD_CLEAR, 0, 0, 0));
    for (k = 0; k < NPTS + 2; k++)
      pending_items.push_back(mk(CMD_APPEND, k * 65536, rnd32(), 0));
    for (k = 0; k < 20; k++)
      pending_items.push_back(mk(CMD_QUERY, $urandom_range(0, 300 * 65536), 0,
                                 $urandom_range(0, 3)));
    wait_drained();

    for (k = 0; k < 40; k++) begin
      if (k == 14) begin
        wait_drained();
        send_idle_pct = 70; recv_idle_pct = 24;
      end
      if (k == 28) begin
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(mk(cmd_e'($urandom_range(0, 3)), rnd32(), rnd32(),
                                   $urandom_range(0, 3)));
      end
      add_profile_phase($urandom_range(2, 12), $urandom_range(5, 14));
    end
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycles > 3000000);
    $display("Checked %0d results: %0d out-of-range queries, %0d dropped appends.",
             results_seen, queries_range, drops);
    if (stim_done && errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (!stim_done) $display("Timeout after %0d cycles.", cycles);
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/plpl_pkg.sv
src/plpl_store.sv
src/plpl_div.sv
src/piecewise_linear_profile_lookup_unit.sv
dv/testbench.sv
